@@ rtl/core/rltc_pkg.sv @@
// ----------------------------------------------------------------------------
// rltc_pkg
// Types and codes shared by the redo log group-commit controller.
// ----------------------------------------------------------------------------
package rltc_pkg;

  // log table geometry
  localparam int TABLE_DEPTH = 30;
  localparam int IDX_W       = 5;
  localparam int BLK_W       = 32;
  localparam int CNT_W       = 5;
  localparam int OPS_W       = 6;
  localparam int CFG_ADDR_W  = 2;

  // command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_LOG   = 2'd2;

  // status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_ENDED    = 3'd2;
  localparam logic [2:0] ST_ABSORBED = 3'd3;
  localparam logic [2:0] ST_APPENDED = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_NO_OP    = 3'd6;
  localparam logic [2:0] ST_NO_BEGIN = 3'd7;

  // disk action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_COPY   = 2'd1;
  localparam logic [1:0] ACT_HEADER = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LOG_START  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOG_BLOCKS = 2'd1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_SEARCH,
    S_CP_RD,
    S_CP_WR,
    S_HDR1,
    S_BK_RD,
    S_BK_WR,
    S_HDR0
  } state_t;

  // one result item
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] header_count;
    logic [BLK_W-1:0] dest_block;
    logic [BLK_W-1:0] source_block;
    logic [1:0]       disk_action;
    logic [2:0]       status;
  } result_t;

endpackage

@@ rtl/core/redo_log_transaction_controller.sv @@
// ----------------------------------------------------------------------------
// redo_log_transaction_controller
// Group-commit redo log controller with a shared compare/address sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one command per transfer, in_tuser = command, in_tdata = block.
//   out_*  : result items; out_tlast marks the final item of a command.
//   cfg_*  : register writes (index 0 log start, 1 log area size), always
//            ready; write only while the block is idle.
// Per command, with the receiver always ready:
//   begin, end and rejected log commands: one result.
//   log block: the sequencer reads one table entry per cycle from the table
//   memory and compares it with the one comparator, and stops early on a hit.
//   committing end: 2 * logged_count + 2 results; each copy needs a table
//   read state and an output state.
//   in_tready is high only while the sequencer is idle; one command at a
//   time.
// A stalled receiver holds the output register and the sequencer waits at
// the next result. Reset clears the counters and the sequencer; the table
// memory is not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module redo_log_transaction_controller #(
  parameter int LOG_CAPACITY = 30,
  parameter int OP_RESERVE   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] block_number
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [34:3] source_block, [66:35] dest_block, [71:67] header_count
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] disk_action
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rltc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0] cfg_data
);

  localparam int RSV_W  = $clog2(OP_RESERVE + 1);
  localparam int NEED_W = rltc_pkg::OPS_W + 1 + RSV_W + 1;
  localparam logic [RSV_W-1:0]  RESERVE = RSV_W'(OP_RESERVE);
  localparam logic [NEED_W-1:0] CAP     = NEED_W'(LOG_CAPACITY);
  localparam logic [rltc_pkg::CNT_W-1:0] CAP_CNT = rltc_pkg::CNT_W'(LOG_CAPACITY);
  localparam logic [rltc_pkg::CNT_W-1:0] DEPTH_CNT =
    rltc_pkg::CNT_W'(rltc_pkg::TABLE_DEPTH);

  rltc_pkg::state_t state_r, state_nxt;

  logic [rltc_pkg::OPS_W-1:0] open_r, open_nxt;
  logic [rltc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [rltc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       pend_r, pend_nxt;
  logic [rltc_pkg::BLK_W-1:0] blk_r, blk_nxt;
  logic [2:0]                 resp_r, resp_nxt;
  logic [31:0]                start_r, areablk_r;
  logic                       out_valid_r, out_valid_nxt;
  rltc_pkg::result_t          out_r, out_nxt;

  logic [rltc_pkg::BLK_W-1:0] mem [rltc_pkg::TABLE_DEPTH];
  logic [rltc_pkg::BLK_W-1:0] rd_data_r;
  logic                       mem_we, mem_re;

  logic                       in_xfer, out_free, out_load, match;
  logic [NEED_W-1:0]          need;
  logic                       log_full;
  logic [31:0]                slot_addr;

  assign in_tready  = (state_r == rltc_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;

  // begin admission and log full checks
  assign need = NEED_W'(count_r) +
                NEED_W'((NEED_W'(open_r) + NEED_W'(1)) * NEED_W'(RESERVE));
  assign log_full = (count_r >= CAP_CNT) || (count_r >= DEPTH_CNT) ||
                    ({28'd0, count_r} + 33'd1 >= {1'b0, areablk_r});

  // shared comparator and slot address adder
  assign match     = pend_r && (rd_data_r == blk_r);
  assign slot_addr = start_r + 32'd1 + {27'd0, idx_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rltc_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            rltc_pkg::CMD_BEGIN: state_nxt = rltc_pkg::S_RESP;
            rltc_pkg::CMD_END: begin
              if (open_r == rltc_pkg::OPS_W'(1) && count_r != '0)
                state_nxt = rltc_pkg::S_CP_RD;
              else
                state_nxt = rltc_pkg::S_RESP;
            end
            rltc_pkg::CMD_LOG: begin
              if (log_full || open_r == '0) state_nxt = rltc_pkg::S_RESP;
              else state_nxt = rltc_pkg::S_SEARCH;
            end
            default: state_nxt = rltc_pkg::S_IDLE;
          endcase
        end
      end
      rltc_pkg::S_RESP:   if (out_free) state_nxt = rltc_pkg::S_IDLE;
      rltc_pkg::S_SEARCH: begin
        if (match || idx_r == count_r) state_nxt = rltc_pkg::S_RESP;
      end
      rltc_pkg::S_CP_RD: begin
        if (idx_r == count_r) state_nxt = rltc_pkg::S_HDR1;
        else state_nxt = rltc_pkg::S_CP_WR;
      end
      rltc_pkg::S_CP_WR:  if (out_free) state_nxt = rltc_pkg::S_CP_RD;
      rltc_pkg::S_HDR1:   if (out_free) state_nxt = rltc_pkg::S_BK_RD;
      rltc_pkg::S_BK_RD: begin
        if (idx_r == count_r) state_nxt = rltc_pkg::S_HDR0;
        else state_nxt = rltc_pkg::S_BK_WR;
      end
      rltc_pkg::S_BK_WR:  if (out_free) state_nxt = rltc_pkg::S_BK_RD;
      rltc_pkg::S_HDR0:   if (out_free) state_nxt = rltc_pkg::S_IDLE;
      default:            state_nxt = rltc_pkg::S_IDLE;
    endcase
  end

  // datapath and output controls
  always_comb begin
    open_nxt  = open_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    blk_nxt   = blk_r;
    resp_nxt  = resp_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    out_nxt   = '0;
    out_nxt.last = 1'b1;
    unique case (state_r) inside
      rltc_pkg::S_IDLE: begin
        idx_nxt  = '0;
        pend_nxt = 1'b0;
        blk_nxt  = in_tdata;
        if (in_xfer) begin
          case (in_tuser)
            rltc_pkg::CMD_BEGIN: begin
              if (need > CAP) begin
                resp_nxt = rltc_pkg::ST_WAIT;
              end else begin
                resp_nxt = rltc_pkg::ST_GRANTED;
                open_nxt = open_r + rltc_pkg::OPS_W'(1);
              end
            end
            rltc_pkg::CMD_END: begin
              if (open_r == '0) begin
                resp_nxt = rltc_pkg::ST_NO_BEGIN;
              end else begin
                resp_nxt = rltc_pkg::ST_ENDED;
                open_nxt = open_r - rltc_pkg::OPS_W'(1);
              end
            end
            rltc_pkg::CMD_LOG: begin
              if (log_full) resp_nxt = rltc_pkg::ST_FULL;
              else resp_nxt = rltc_pkg::ST_NO_OP;
            end
            default: resp_nxt = resp_r;
          endcase
        end
      end
      rltc_pkg::S_RESP: begin
        out_nxt.status = resp_r;
        out_load       = out_free;
      end
      rltc_pkg::S_SEARCH: begin
        // compare the entry read last cycle while reading the next one
        if (match) begin
          resp_nxt = rltc_pkg::ST_ABSORBED;
        end else if (idx_r == count_r) begin
          resp_nxt  = rltc_pkg::ST_APPENDED;
          mem_we    = 1'b1;
          count_nxt = count_r + rltc_pkg::CNT_W'(1);
        end else begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + rltc_pkg::IDX_W'(1);
          pend_nxt = 1'b1;
        end
      end
      rltc_pkg::S_CP_RD, rltc_pkg::S_BK_RD: begin
        mem_re = (idx_r != count_r);
      end
      rltc_pkg::S_CP_WR: begin
        // logged block into its log slot
        out_nxt.status       = rltc_pkg::ST_ENDED;
        out_nxt.disk_action  = rltc_pkg::ACT_COPY;
        out_nxt.source_block = rd_data_r;
        out_nxt.dest_block   = slot_addr;
        out_nxt.last         = 1'b0;
        out_load             = out_free;
        if (out_free) idx_nxt = idx_r + rltc_pkg::IDX_W'(1);
      end
      rltc_pkg::S_HDR1: begin
        out_nxt.status       = rltc_pkg::ST_ENDED;
        out_nxt.disk_action  = rltc_pkg::ACT_HEADER;
        out_nxt.dest_block   = start_r;
        out_nxt.header_count = count_r;
        out_nxt.last         = 1'b0;
        out_load             = out_free;
        if (out_free) idx_nxt = '0;
      end
      rltc_pkg::S_BK_WR: begin
        // log slot back to its home block
        out_nxt.status       = rltc_pkg::ST_ENDED;
        out_nxt.disk_action  = rltc_pkg::ACT_COPY;
        out_nxt.source_block = slot_addr;
        out_nxt.dest_block   = rd_data_r;
        out_nxt.last         = 1'b0;
        out_load             = out_free;
        if (out_free) idx_nxt = idx_r + rltc_pkg::IDX_W'(1);
      end
      rltc_pkg::S_HDR0: begin
        out_nxt.status      = rltc_pkg::ST_ENDED;
        out_nxt.disk_action = rltc_pkg::ACT_HEADER;
        out_nxt.dest_block  = start_r;
        out_load            = out_free;
        if (out_free) count_nxt = '0;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rltc_pkg::S_IDLE;
      open_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= 32'd2;
      areablk_r   <= 32'd30;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          rltc_pkg::REG_LOG_START:  start_r   <= cfg_data;
          rltc_pkg::REG_LOG_BLOCKS: areablk_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    resp_r <= resp_nxt;
    if (out_load) out_r <= out_nxt;
  end

  // block number table
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r] <= blk_r;
    if (mem_re) rd_data_r <= mem[idx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.header_count, out_r.dest_block, out_r.source_block,
                       out_r.status};
  assign out_tuser  = out_r.disk_action;
  assign out_tlast  = out_r.last;

  // table never overflows
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("logged count beyond table depth");

  // search never reads past the filled part of the table
  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rltc_pkg::S_SEARCH) |-> (idx_r <= count_r))
    else $error("search index beyond logged count");

  // closing header write empties the table
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rltc_pkg::S_HDR0 && out_free) |=>
      (count_r == '0 && open_r == '0 && out_tlast))
    else $error("commit did not clear the table");

endmodule
